// ===== rtl/weighted_range_dispatcher_with_stealing_defines.svh =====
// ----------------------------------------------------------------------------
// wrds assertion macros
// shared property templates for the dispatcher checks
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANGE_DISPATCHER_WITH_STEALING_DEFINES_SVH
`define WEIGHTED_RANGE_DISPATCHER_WITH_STEALING_DEFINES_SVH

// same-cycle implication
`define WRDS_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WRDS_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wrds_pkg.sv =====
// ----------------------------------------------------------------------------
// wrds_pkg
// types, codes and the percent table of the range dispatcher
// ----------------------------------------------------------------------------
package wrds_pkg;

	localparam int TOTAL_W         = 64;
	localparam int OP_W            = 2;
	localparam int WID_W           = 3;
	localparam int SLOT_W          = 3;
	localparam int PCT_W           = 7;
	localparam int REM_W           = 7;
	localparam int MAX_WORKERS_DEF = 7;
	localparam int PCT_ROWS        = 7;
	localparam int RECIP_SHIFT     = 19;

	localparam logic [OP_W-1:0] OP_BUILD   = 2'd0;
	localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
	localparam logic [OP_W-1:0] OP_DONE    = 2'd2;
	localparam logic [OP_W-1:0] OP_FOUND   = 2'd3;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_EXIT   = 1'b1;

	localparam logic CFG_TOTAL   = 1'b0;
	localparam logic CFG_WORKERS = 1'b1;

	localparam logic [TOTAL_W-1:0] TOTAL_RST   = 64'd128;
	localparam logic [WID_W-1:0]   WORKERS_RST = 3'd1;
	localparam logic [REM_W-1:0]   DIV_HUNDRED = 7'd100;
	localparam logic [12:0]        RECIP_100   = 13'd5243;

	localparam logic [PCT_W-1:0] PCT_TABLE [PCT_ROWS][PCT_ROWS] = '{
		'{7'd100, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd40,  7'd60, 7'd0,  7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd25,  7'd30, 7'd45, 7'd0,  7'd0,  7'd0,  7'd0},
		'{7'd10,  7'd20, 7'd30, 7'd40, 7'd0,  7'd0,  7'd0},
		'{7'd8,   7'd10, 7'd20, 7'd28, 7'd34, 7'd0,  7'd0},
		'{7'd4,   7'd6,  7'd10, 7'd19, 7'd25, 7'd36, 7'd0},
		'{7'd2,   7'd3,  7'd6,  7'd12, 7'd19, 7'd28, 7'd30}
	};

	typedef struct packed {
		logic [TOTAL_W-1:0] rng_begin;
		logic [TOTAL_W-1:0] rng_limit;
		logic [WID_W-1:0]   owner;
		logic               finished;
	} slice_t;

	typedef struct packed {
		logic               start;
		logic [TOTAL_W-1:0] dividend;
		logic [REM_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [TOTAL_W-1:0] quot;
		logic [REM_W-1:0]   rem;
	} div_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		slice_t            wr_data;
	} mem_req_t;

	function automatic logic [PCT_W-1:0] pct_lookup(logic [WID_W-1:0] n, logic [SLOT_W-1:0] i);
		logic [PCT_W-1:0] p;
		p = '0;
		if (n != '0 && i != 3'd7)
			p = PCT_TABLE[n - 3'd1][i];
		return p;
	endfunction

endpackage

// ===== rtl/wrds_in_if.sv =====
// ----------------------------------------------------------------------------
// wrds_in_if
// request and event channel of the dispatcher
// ----------------------------------------------------------------------------
interface wrds_in_if import wrds_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [WID_W-1:0] worker_id;

	modport source (output valid, opcode, worker_id, input ready);
	modport sink (input valid, opcode, worker_id, output ready);
endinterface

// ===== rtl/wrds_out_if.sv =====
// ----------------------------------------------------------------------------
// wrds_out_if
// reply channel of the dispatcher
// ----------------------------------------------------------------------------
interface wrds_out_if import wrds_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               reply_kind;
	logic [WID_W-1:0]   target_worker;
	logic [TOTAL_W-1:0] range_begin;
	logic [TOTAL_W-1:0] range_limit;
	logic               last_reply;

	modport source (output valid, reply_kind, target_worker, range_begin, range_limit,
		last_reply, input ready);
	modport sink (input valid, reply_kind, target_worker, range_begin, range_limit,
		last_reply, output ready);
endinterface

// ===== rtl/weighted_range_dispatcher_with_stealing.sv =====
// ----------------------------------------------------------------------------
// weighted_range_dispatcher_with_stealing
// hands out weighted slices of a job range to workers, steals half of a
// large open slice when none is free, exits workers when out of work
// ----------------------------------------------------------------------------
// build: bytewise divide by 100, then serial divide by n, then BMUL, BSUM and
// BWR for each of the MAX_WORKERS slots
// request: scan of the n slots, decide, then the reply; done: scan and decide
// found: one exit transfer per cycle unless out_ch stalls, n exits, via the single reply register
// reset: slice table reads as zero, control registers at reset values, channel idle
// ----------------------------------------------------------------------------
`include "weighted_range_dispatcher_with_stealing_defines.svh"

module weighted_range_dispatcher_with_stealing import wrds_pkg::*; #(
	parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wrds_in_if.sink            in_ch,
	wrds_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [TOTAL_W-1:0] cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DIV100 = 4'd1;
	localparam logic [3:0] ST_DIVN   = 4'd2;
	localparam logic [3:0] ST_BMUL   = 4'd3;
	localparam logic [3:0] ST_BSUM   = 4'd4;
	localparam logic [3:0] ST_BWR    = 4'd5;
	localparam logic [3:0] ST_SCAN   = 4'd6;
	localparam logic [3:0] ST_DECIDE = 4'd7;
	localparam logic [3:0] ST_EMIT   = 4'd8;
	localparam logic [3:0] ST_FOUND  = 4'd9;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_WORKERS - 1);
	localparam logic [WID_W-1:0]  MAX_N     = WID_W'(MAX_WORKERS);

	logic [3:0]         state_q;
	logic [TOTAL_W-1:0] total_q;
	logic [WID_W-1:0]   wc_q;
	logic [TOTAL_W-1:0] floor_q;
	logic [WID_W-1:0]   exited_q;
	logic [OP_W-1:0]    op_q;
	logic [WID_W-1:0]   wid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [2:0]         dcnt_q;
	logic [TOTAL_W-1:0] q100_q;
	logic [REM_W-1:0]   r100_q;
	logic [TOTAL_W-1:0] beg_q;
	logic [TOTAL_W-1:0] prod_s1;
	logic [13:0]        rp_s1;
	logic [TOTAL_W-1:0] size_s2;
	logic               chk_v_s1;

	logic               free_hit_q;
	logic [SLOT_W-1:0]  free_idx_q;
	slice_t             free_ent_q;
	logic               steal_hit_q;
	logic [SLOT_W-1:0]  steal_idx_q;
	slice_t             steal_ent_q;
	logic [TOTAL_W-1:0] steal_len_q;
	logic               own_hit_q;
	logic [SLOT_W-1:0]  own_idx_q;
	slice_t             own_ent_q;
	logic [SLOT_W-1:0]  chk_idx_s1;

	logic               res_kind_q;
	logic [TOTAL_W-1:0] res_begin_q;
	logic [TOTAL_W-1:0] res_limit_q;

	logic               out_vld_q;
	logic               out_kind_q;
	logic [WID_W-1:0]   out_tgt_q;
	logic [TOTAL_W-1:0] out_begin_q;
	logic [TOTAL_W-1:0] out_limit_q;
	logic               out_last_q;

	logic [WID_W-1:0]   n_eff;
	logic               accept;
	logic               out_free;
	logic               out_load;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	mem_req_t           mem_req;
	slice_t             rd_ent;
	slice_t             build_ent;
	logic [TOTAL_W-1:0] build_lim;
	logic [26:0]        frac_full;
	logic [14:0]        dv_num;
	logic [27:0]        dv_prod;
	logic [7:0]         dv_quo;
	logic [REM_W-1:0]   dv_rem;
	logic [TOTAL_W-1:0] ent_len;
	logic               free_c;
	logic               own_c;
	logic               steal_c;
	logic               dec_wr;
	logic [SLOT_W-1:0]  dec_addr;
	slice_t             dec_ent;
	logic               dec_kind;
	logic [TOTAL_W-1:0] dec_begin;
	logic [TOTAL_W-1:0] dec_limit;

	assign n_eff = (wc_q == '0) ? 3'd1 : ((wc_q > MAX_N) ? MAX_N : wc_q);
	assign in_ch.ready = state_q == ST_IDLE;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_free = !out_vld_q || out_ch.ready;
	assign out_load = (state_q == ST_EMIT || state_q == ST_FOUND) && out_free;

	wrds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wrds_slice_mem #(.DEPTH(MAX_WORKERS)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_ent)
	);

	// divide by 100 one byte per cycle, msb first
	assign dv_num  = {r100_q, q100_q[TOTAL_W-1:TOTAL_W-8]};
	assign dv_prod = 28'(dv_num) * 28'(RECIP_100);
	assign dv_quo  = dv_prod[RECIP_SHIFT+7:RECIP_SHIFT];
	assign dv_rem  = REM_W'(dv_num - 15'(dv_quo) * 15'(DIV_HUNDRED));

	// divider request for the worker count
	always_comb begin
		div_req.start    = state_q == ST_DIV100 && dcnt_q == 3'd7;
		div_req.dividend = total_q;
		div_req.divisor  = REM_W'(n_eff);
	end

	// slice arithmetic for the table build
	assign frac_full = 27'(rp_s1) * 27'(RECIP_100);
	assign build_lim = (slot_q == n_eff - 3'd1) ? total_q : beg_q + size_s2;
	always_comb begin
		build_ent = '0;
		if (slot_q < n_eff) begin
			build_ent.rng_begin = beg_q;
			build_ent.rng_limit = build_lim;
		end
	end

	// scan checks on the entry just read
	assign ent_len = rd_ent.rng_limit - rd_ent.rng_begin;
	assign free_c  = !rd_ent.finished && rd_ent.owner == '0;
	assign own_c   = !rd_ent.finished && rd_ent.owner == wid_q;
	assign steal_c = !rd_ent.finished && rd_ent.owner != '0 && rd_ent.owner != wid_q
		&& rd_ent.rng_limit >= rd_ent.rng_begin && ent_len > floor_q;

	// outcome of a request or done event
	always_comb begin
		dec_wr    = 1'b0;
		dec_addr  = own_idx_q;
		dec_ent   = own_ent_q;
		dec_ent.finished = 1'b1;
		dec_kind  = KIND_EXIT;
		dec_begin = '0;
		dec_limit = '0;
		if (op_q == OP_REQUEST) begin
			if (free_hit_q) begin
				dec_wr        = 1'b1;
				dec_addr      = free_idx_q;
				dec_ent       = free_ent_q;
				dec_ent.owner = wid_q;
				dec_kind      = KIND_ASSIGN;
				dec_begin     = free_ent_q.rng_begin;
				dec_limit     = free_ent_q.rng_limit;
			end else if (steal_hit_q) begin
				dec_wr            = 1'b1;
				dec_addr          = steal_idx_q;
				dec_ent           = steal_ent_q;
				dec_ent.rng_begin = steal_ent_q.rng_limit;
				dec_kind          = KIND_ASSIGN;
				dec_begin         = steal_ent_q.rng_begin + (steal_len_q >> 1);
				dec_limit         = steal_ent_q.rng_limit;
			end else begin
				dec_wr = own_hit_q;
			end
		end else begin
			dec_wr = own_hit_q;
		end
	end

	// slice memory port
	always_comb begin
		mem_req.rd_en   = state_q == ST_SCAN && slot_q < n_eff;
		mem_req.rd_addr = slot_q;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = slot_q;
		mem_req.wr_data = build_ent;
		if (state_q == ST_BWR) begin
			mem_req.wr_en = 1'b1;
		end else if (state_q == ST_DECIDE) begin
			mem_req.wr_en   = dec_wr;
			mem_req.wr_addr = dec_addr;
			mem_req.wr_data = dec_ent;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= TOTAL_RST;
			wc_q        <= WORKERS_RST;
			floor_q     <= '0;
			exited_q    <= '0;
			slot_q      <= '0;
			dcnt_q      <= '0;
			chk_v_s1    <= 1'b0;
			free_hit_q  <= 1'b0;
			steal_hit_q <= 1'b0;
			own_hit_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOTAL:   total_q <= cfg_data;
					CFG_WORKERS: wc_q <= cfg_data[WID_W-1:0];
					default:     total_q <= total_q;
				endcase
			end
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
			chk_v_s1 <= state_q == ST_SCAN && slot_q < n_eff;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.opcode == OP_BUILD) begin
							dcnt_q  <= '0;
							state_q <= ST_DIV100;
						end else if (exited_q >= n_eff) begin
							state_q <= ST_IDLE;
						end else if (in_ch.opcode == OP_FOUND) begin
							exited_q <= n_eff;
							slot_q   <= 3'd1;
							state_q  <= ST_FOUND;
						end else if (in_ch.worker_id != '0) begin
							slot_q      <= '0;
							free_hit_q  <= 1'b0;
							steal_hit_q <= 1'b0;
							own_hit_q   <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_DIV100: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == 3'd7)
						state_q <= ST_DIVN;
				end
				ST_DIVN: begin
					if (div_rsp.done) begin
						floor_q  <= div_rsp.quot >> 2;
						exited_q <= '0;
						slot_q   <= '0;
						state_q  <= ST_BMUL;
					end
				end
				ST_BMUL: state_q <= ST_BSUM;
				ST_BSUM: state_q <= ST_BWR;
				ST_BWR: begin
					if (slot_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end else begin
						slot_q  <= slot_q + 3'd1;
						state_q <= ST_BMUL;
					end
				end
				ST_SCAN: begin
					if (slot_q < n_eff) begin
						slot_q <= slot_q + 3'd1;
					end else if (!chk_v_s1) begin
						state_q <= ST_DECIDE;
					end
					if (chk_v_s1) begin
						if (free_c && !free_hit_q)
							free_hit_q <= 1'b1;
						if (steal_c && !steal_hit_q)
							steal_hit_q <= 1'b1;
						if (own_c && !own_hit_q)
							own_hit_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_REQUEST) begin
						if (!free_hit_q && !steal_hit_q && exited_q != 3'd7)
							exited_q <= exited_q + 3'd1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_FOUND: begin
					if (out_free) begin
						if (slot_q == n_eff)
							state_q <= ST_IDLE;
						else
							slot_q <= slot_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_ch.opcode;
			wid_q <= in_ch.worker_id;
		end
		if (accept && in_ch.opcode == OP_BUILD) begin
			q100_q <= total_q;
			r100_q <= '0;
		end
		if (state_q == ST_DIV100) begin
			q100_q <= {q100_q[TOTAL_W-9:0], dv_quo};
			r100_q <= dv_rem;
		end
		if (state_q == ST_DIVN)
			beg_q <= '0;
		if (state_q == ST_BMUL) begin
			prod_s1 <= q100_q * {57'd0, pct_lookup(n_eff, slot_q)};
			rp_s1   <= 14'(r100_q) * 14'(pct_lookup(n_eff, slot_q));
		end
		if (state_q == ST_BSUM)
			size_s2 <= prod_s1 + {56'd0, frac_full[26:RECIP_SHIFT]};
		if (state_q == ST_BWR && slot_q < n_eff)
			beg_q <= build_lim;
		if (state_q == ST_SCAN)
			chk_idx_s1 <= slot_q;
		if (chk_v_s1) begin
			if (free_c && !free_hit_q) begin
				free_idx_q <= chk_idx_s1;
				free_ent_q <= rd_ent;
			end
			if (steal_c && !steal_hit_q) begin
				steal_idx_q <= chk_idx_s1;
				steal_ent_q <= rd_ent;
				steal_len_q <= ent_len;
			end
			if (own_c && !own_hit_q) begin
				own_idx_q <= chk_idx_s1;
				own_ent_q <= rd_ent;
			end
		end
		if (state_q == ST_DECIDE) begin
			res_kind_q  <= dec_kind;
			res_begin_q <= dec_begin;
			res_limit_q <= dec_limit;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_kind_q  <= res_kind_q;
			out_tgt_q   <= wid_q;
			out_begin_q <= res_begin_q;
			out_limit_q <= res_limit_q;
			out_last_q  <= 1'b1;
		end
		if (state_q == ST_FOUND && out_free) begin
			out_kind_q  <= KIND_EXIT;
			out_tgt_q   <= slot_q;
			out_begin_q <= '0;
			out_limit_q <= '0;
			out_last_q  <= slot_q == n_eff;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.reply_kind    = out_kind_q;
	assign out_ch.target_worker = out_tgt_q;
	assign out_ch.range_begin   = out_begin_q;
	assign out_ch.range_limit   = out_limit_q;
	assign out_ch.last_reply    = out_last_q;

	`WRDS_ASSERT_IMP(a_exit_zero, clk, arst_n, out_ch.valid && out_ch.reply_kind == KIND_EXIT, out_ch.range_begin == '0 && out_ch.range_limit == '0, "exit transfer carries a range")
	`WRDS_ASSERT_IMP(a_div_state, clk, arst_n, div_rsp.busy, state_q == ST_DIV100 || state_q == ST_DIVN, "divider runs outside a build")
	`WRDS_ASSERT_NXT(a_all_exited, clk, arst_n, accept && in_ch.opcode != OP_BUILD && exited_q >= n_eff, state_q == ST_IDLE, "event served after all workers exited")

endmodule

// ===== rtl/wrds_div.sv =====
// ----------------------------------------------------------------------------
// wrds_div
// bit-serial restoring divider, 64-bit dividend by a small divisor
// ----------------------------------------------------------------------------
module wrds_div import wrds_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [5:0]         cnt_q;
	logic [TOTAL_W-1:0] quot_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   dsr_q;
	logic [REM_W:0]     trial;
	logic               fits;

	assign trial = {rem_q, quot_q[TOTAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[TOTAL_W-2:0], fits};
			if (fits)
				rem_q <= REM_W'(trial - {1'b0, dsr_q});
			else
				rem_q <= trial[REM_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/wrds_slice_mem.sv =====
// ----------------------------------------------------------------------------
// wrds_slice_mem
// slice table, one write and one registered read port, entries read as zero
// until written
// ----------------------------------------------------------------------------
module wrds_slice_mem import wrds_pkg::*; #(
	parameter int DEPTH = MAX_WORKERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output slice_t   rd_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	slice_t           mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	slice_t           rd_data_s1;
	logic             wr_ok;
	logic             rd_ok;

	assign wr_ok = req.wr_en && (32'(req.wr_addr) < DEPTH);
	assign rd_ok = 32'(req.rd_addr) < DEPTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[req.wr_addr[IW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok)
			mem_q[req.wr_addr[IW-1:0]] <= req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			if (rd_ok && vld_q[req.rd_addr[IW-1:0]])
				rd_data_s1 <= mem_q[req.rd_addr[IW-1:0]];
			else
				rd_data_s1 <= '0;
		end
	end

	assign rd_data = rd_data_s1;

endmodule

// ===== verif/tb_weighted_range_dispatcher_with_stealing.sv =====
// ----------------------------------------------------------------------------
// tb_weighted_range_dispatcher_with_stealing
// drives build, request, done and found events through the event channel and
// compares every reply against an in-bench model of the slice table, over
// several range sizes and worker counts, with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_weighted_range_dispatcher_with_stealing;
	import wrds_pkg::*;

	typedef struct packed {
		logic               kind;
		logic [WID_W-1:0]   target;
		logic [TOTAL_W-1:0] rbeg;
		logic [TOTAL_W-1:0] rlim;
		logic               last;
	} reply_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [WID_W-1:0] wid;
		logic             chk;
		reply_t           rep;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_TOTAL;
	logic [TOTAL_W-1:0] cfg_data = '0;
	int errors = 0;

	wrds_in_if in_ch ();
	wrds_out_if out_ch ();

	weighted_range_dispatcher_with_stealing DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic [TOTAL_W-1:0] m_total = TOTAL_RST;
	logic [WID_W-1:0]   m_workers = WORKERS_RST;
	logic [TOTAL_W-1:0] sl_beg [7];
	logic [TOTAL_W-1:0] sl_lim [7];
	logic [WID_W-1:0]   sl_own [7];
	logic               sl_fin [7];
	logic [TOTAL_W-1:0] m_floor;
	int                 m_exited;
	reply_t             pending_replies [$];

	function automatic int active_workers();
		return (m_workers == 0) ? 1 : int'(m_workers);
	endfunction

	function automatic int own_open(int n, logic [WID_W-1:0] w);
		for (int i = 0; i < n; i++)
			if (sl_own[i] == w && !sl_fin[i]) return i;
		return -1;
	endfunction

	function automatic void push_reply(logic k, logic [WID_W-1:0] t, logic [TOTAL_W-1:0] b,
		logic [TOTAL_W-1:0] l, logic last);
		reply_t r;
		r.kind = k; r.target = t; r.rbeg = b; r.rlim = l; r.last = last;
		pending_replies.push_back(r);
	endfunction

	function automatic void dispatch_event(logic [OP_W-1:0] op, logic [WID_W-1:0] w);
		int n;
		int idx;
		logic [TOTAL_W-1:0] start, sz, p, len;
		n = active_workers();
		if (op == OP_BUILD) begin
			start = '0;
			for (int i = 0; i < 7; i++) begin
				sl_own[i] = '0; sl_fin[i] = 1'b0;
				if (i < n) begin
					p = TOTAL_W'(PCT_TABLE[n-1][i]);
					sz = (m_total / 100) * p + ((m_total % 100) * p) / 100;
					sl_beg[i] = start;
					sl_lim[i] = (i == n - 1) ? m_total : start + sz;
					start = sl_lim[i];
				end else begin
					sl_beg[i] = '0; sl_lim[i] = '0;
				end
			end
			m_floor = (m_total / n) / 4;
			m_exited = 0;
			return;
		end
		if (m_exited >= n) return;
		if (op == OP_FOUND) begin
			for (int i = 0; i < n; i++)
				push_reply(KIND_EXIT, WID_W'(i + 1), '0, '0, i == n - 1);
			m_exited = n;
			return;
		end
		if (w == 0) return;
		if (op == OP_DONE) begin
			idx = own_open(n, w);
			if (idx >= 0) sl_fin[idx] = 1'b1;
			return;
		end
		for (int i = 0; i < n; i++)
			if (!sl_fin[i] && sl_own[i] == 0) begin
				sl_own[i] = w;
				push_reply(KIND_ASSIGN, w, sl_beg[i], sl_lim[i], 1'b1);
				return;
			end
		for (int i = 0; i < n; i++)
			if (sl_own[i] != 0 && sl_own[i] != w && !sl_fin[i]) begin
				len = sl_lim[i] - sl_beg[i];
				if (sl_lim[i] >= sl_beg[i] && len > m_floor) begin
					push_reply(KIND_ASSIGN, w, sl_beg[i] + len / 2, sl_lim[i], 1'b1);
					sl_beg[i] = sl_lim[i];
					return;
				end
			end
		idx = own_open(n, w);
		if (idx >= 0) sl_fin[idx] = 1'b1;
		if (m_exited < 7) m_exited++;
		push_reply(KIND_EXIT, w, '0, '0, 1'b1);
	endfunction

	task automatic write_reg(logic idx, logic [TOTAL_W-1:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TOTAL) m_total = val;
		else m_workers = val[WID_W-1:0];
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_event(logic [OP_W-1:0] op, logic [WID_W-1:0] w);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1; in_ch.opcode <= op; in_ch.worker_id <= w;
		do @(posedge clk); while (!in_ch.ready);
		dispatch_event(op, w);
	endtask

	// sink with random stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_replies.size() == 0) begin
					$error("reply with nothing expected");
					errors++;
				end else begin
					reply_t e;
					e = pending_replies.pop_front();
					if (out_ch.reply_kind !== e.kind) begin
						$error("reply_kind exp %0d got %0d", e.kind, out_ch.reply_kind); errors++;
					end
					if (out_ch.target_worker !== e.target) begin
						$error("target_worker exp %0d got %0d", e.target, out_ch.target_worker);
						errors++;
					end
					if (out_ch.range_begin !== e.rbeg) begin
						$error("range_begin exp %0d got %0d", e.rbeg, out_ch.range_begin); errors++;
					end
					if (out_ch.range_limit !== e.rlim) begin
						$error("range_limit exp %0d got %0d", e.rlim, out_ch.range_limit); errors++;
					end
					if (out_ch.last_reply !== e.last) begin
						$error("last_reply exp %0d got %0d", e.last, out_ch.last_reply); errors++;
					end
				end
				stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	row_t table_rows [$];

	function automatic void add_row(logic [OP_W-1:0] op, logic [WID_W-1:0] w, logic chk = 1'b0,
		logic k = 1'b0, logic [WID_W-1:0] t = '0, logic [TOTAL_W-1:0] b = '0,
		logic [TOTAL_W-1:0] l = '0);
		row_t r;
		r.op = op; r.wid = w; r.chk = chk;
		r.rep.kind = k; r.rep.target = t; r.rep.rbeg = b; r.rep.rlim = l; r.rep.last = 1'b1;
		table_rows.push_back(r);
	endfunction

	initial begin
		logic [TOTAL_W-1:0] totals [6];
		logic [WID_W-1:0] w;
		int sent;
		int r;
		in_ch.valid = 1'b0; in_ch.opcode = OP_BUILD; in_ch.worker_id = '0;
		for (int i = 0; i < 7; i++) begin
			sl_beg[i] = '0; sl_lim[i] = '0; sl_own[i] = '0; sl_fin[i] = 1'b0;
		end
		m_floor = '0; m_exited = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before build: empty range; then reset config 128, one worker
		add_row(OP_REQUEST, 3'd1, 1'b1, KIND_ASSIGN, 3'd1, 64'd0, 64'd0);
		add_row(OP_BUILD, 3'd0);
		add_row(OP_REQUEST, 3'd0);
		add_row(OP_DONE, 3'd0);
		add_row(OP_REQUEST, 3'd7, 1'b1, KIND_ASSIGN, 3'd7, 64'd0, 64'd128);
		add_row(OP_DONE, 3'd5);
		add_row(OP_REQUEST, 3'd2);
		add_row(OP_REQUEST, 3'd7, 1'b1, KIND_EXIT, 3'd7, 64'd0, 64'd0);
		add_row(OP_REQUEST, 3'd3);
		add_row(OP_FOUND, 3'd0);
		add_row(OP_BUILD, 3'd0);
		add_row(OP_FOUND, 3'd4);
		add_row(OP_FOUND, 3'd4);
		foreach (table_rows[i]) begin
			if (table_rows[i].chk) begin
				dispatch_event(table_rows[i].op, table_rows[i].wid);
				if (pending_replies.size() == 0 || pending_replies[$] != table_rows[i].rep) begin
					$error("directed row %0d disagrees with model", i); errors++;
				end
				void'(pending_replies.pop_back());
				pending_replies.push_back(table_rows[i].rep);
				// model already holds this row, only the transfer is left
				in_ch.valid <= 1'b1; in_ch.opcode <= table_rows[i].op;
				in_ch.worker_id <= table_rows[i].wid;
				do @(posedge clk); while (!in_ch.ready);
			end else begin
				send_event(table_rows[i].op, table_rows[i].wid);
			end
		end
		drain();

		// max workers, range 2^63, stealing
		write_reg(CFG_WORKERS, 64'd7);
		write_reg(CFG_TOTAL, 64'h8000_0000_0000_0000);
		send_event(OP_BUILD, 3'd0);
		for (int i = 1; i <= 7; i++) send_event(OP_REQUEST, WID_W'(i));
		send_event(OP_DONE, 3'd2);
		for (int i = 1; i <= 7; i++) send_event(OP_REQUEST, WID_W'(8 - i));
		send_event(OP_FOUND, 3'd1);
		drain();

		totals = '{64'd1, 64'd7, 64'd99, 64'd1000, 64'h0123_4567_89ab_cdef,
			64'h8000_0000_0000_0000};
		sent = 0;
		while (sent < 350) begin
			if (sent % 50 == 0) begin
				drain();
				write_reg(CFG_WORKERS, ($urandom_range(0, 5) == 0) ? 64'd0 :
					64'($urandom_range(1, 7)));
				write_reg(CFG_TOTAL, ($urandom_range(0, 1) == 0) ?
					totals[$urandom_range(0, 5)] : {$urandom, $urandom});
				send_event(OP_BUILD, 3'd0);
				sent++;
			end
			r = $urandom_range(0, 99);
			w = WID_W'($urandom_range(1, active_workers() + 1 > 7 ? 7 : active_workers() + 1));
			if (r < 3) w = 3'd0;
			if (r < 60) send_event(OP_REQUEST, w);
			else if (r < 85) send_event(OP_DONE, w);
			else if (r < 92) send_event(OP_BUILD, WID_W'($urandom_range(0, 7)));
			else if (r < 96) send_event(OP_FOUND, WID_W'($urandom_range(0, 7)));
			else begin
				drain();
				send_event(OP_REQUEST, w);
			end
			sent++;
		end
		drain();
		if (errors == 0) $display("PASS weighted_range_dispatcher_with_stealing");
		else $display("FAIL weighted_range_dispatcher_with_stealing");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL weighted_range_dispatcher_with_stealing");
		$finish;
	end

endmodule
